// ===== rtl/rrtp_pkg.sv =====
// Shared types and codes for the round-robin task picker.
// No dependencies; used by rrtp_scan_acc and round_robin_task_picker.
package rrtp_pkg;

   localparam int SLOTS_DEF = 64;
   localparam int CPUS_DEF  = 8;

   localparam int SLOT_W   = 6;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;
   localparam int CPU_W    = 3;
   localparam int OUT_W    = 2;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [KIND_W-1:0] KIND_IDLE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_GUEST = 2'd2;

   localparam logic [STATUS_W-1:0] ST_RUNNABLE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RUNNING  = 2'd2;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_SCHED = 1'b1;

   localparam logic [OUT_W-1:0] OUT_RUN    = 2'd0;
   localparam logic [OUT_W-1:0] OUT_NONE   = 2'd1;
   localparam logic [OUT_W-1:0] OUT_NOIDLE = 2'd2;
   localparam logic [OUT_W-1:0] OUT_WRITE  = 2'd3;

   // register index is paddr[2]
   localparam logic REG_SKIP_GUEST = 1'b0;
   localparam logic REG_RUN_GUEST  = 1'b1;

   // one entry read back from the slot table during a scan
   typedef struct packed {
      logic                valid;
      logic                last;   // entry at the current slot's position
      logic [KIND_W-1:0]   kind;
      logic [STATUS_W-1:0] status;
   } scan_beat_type;

endpackage

// ===== rtl/round_robin_task_picker.sv =====
// Round-robin task picker. A write item updates the slot table at acceptance;
// its result goes through DONE to the result register. A schedule item scans
// the whole table (one table read per cycle), then goes through DRAIN and DONE.
// No new item is taken until the last result is in the result register; the
// single-read-port slot table sets the scan length. Reset: synchronous; clears
// registers, then zeroes the slot table, taking no item meanwhile (APB writes are).
module round_robin_task_picker import rrtp_pkg::*; #(
   parameter int SLOTS = SLOTS_DEF,
   parameter int CPUS  = CPUS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_action,
   input  logic [SLOT_W-1:0]   req_slot_index,
   input  logic [KIND_W-1:0]   req_slot_kind,
   input  logic [STATUS_W-1:0] req_slot_status,
   input  logic                req_have_current,
   input  logic [SLOT_W-1:0]   req_current_slot,
   input  logic [CPU_W-1:0]    req_cpu_number,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [OUT_W-1:0]    rsp_outcome,
   output logic [SLOT_W-1:0]   rsp_chosen_slot,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CSR_AW-1:0]   paddr,
   input  logic [CSR_DW-1:0]   pwdata,
   output logic [CSR_DW-1:0]   prdata,
   output logic                pready
);

   localparam int IW = $clog2(SLOTS);
   localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [IW-1:0] addr_ff, addr_in, cnt_ff, cnt_in, addr_next;
   logic          skip_guest_ff, run_guest_ff;
   logic          is_sched_ff, have_cur_ff;
   logic [CPU_W-1:0] cpu_ff;
   logic          rsp_valid_ff;
   logic [OUT_W-1:0]  rsp_outcome_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;

   logic [KIND_W+STATUS_W-1:0] mem [SLOTS];
   logic [KIND_W+STATUS_W-1:0] rd_data_ff;
   logic          ev_valid_ff, ev_last_ff;
   logic [IW-1:0] ev_addr_ff;

   logic          req_accept, out_free, csr_write;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [KIND_W+STATUS_W-1:0] wr_data;
   logic [IW-1:0] cur_mod_tab [2**SLOT_W];
   logic [IW-1:0] cur_mod, scan_start;
   scan_beat_type beat;
   logic [OUT_W-1:0]  dec_outcome;
   logic [SLOT_W-1:0] dec_slot;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_guest_ff <= 1'b0;
         run_guest_ff  <= 1'b0;
      end else if (csr_write) begin
         case (paddr[2])
            REG_SKIP_GUEST: skip_guest_ff <= pwdata[0];
            REG_RUN_GUEST:  run_guest_ff  <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_SKIP_GUEST: prdata = {{(CSR_DW-1){1'b0}}, skip_guest_ff};
         REG_RUN_GUEST:  prdata = {{(CSR_DW-1){1'b0}}, run_guest_ff};
         default:        prdata = '0;
      endcase
   end

   // ---------------- handshakes ----------------
   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // current slot modulo SLOTS through a constant table
   for (genvar g = 0; g < 2**SLOT_W; g++) begin : g_mod
      assign cur_mod_tab[g] = IW'(g % SLOTS);
   end
   assign cur_mod    = cur_mod_tab[req_current_slot];
   assign scan_start = !req_have_current ? '0 : (cur_mod == LAST) ? '0 : cur_mod + 1'b1;
   assign addr_next  = (addr_ff == LAST) ? '0 : addr_ff + 1'b1;

   // ---------------- slot table ----------------
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = '0;
      if (state_ff == S_CLEAR) begin
         wr_en = 1'b1;
      end else if (req_accept && req_action == ACT_WRITE &&
                   32'(req_slot_index) < 32'(SLOTS)) begin
         wr_en   = 1'b1;
         wr_addr = IW'(req_slot_index);
         wr_data = {req_slot_kind, req_slot_status};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[addr_ff];
      ev_addr_ff <= addr_ff;
      ev_last_ff <= (cnt_ff == LAST);
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_CLEAR: begin
            addr_in = addr_next;
            if (addr_ff == LAST) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_accept) begin
               if (req_action == ACT_SCHED) begin
                  addr_in  = scan_start;
                  cnt_in   = '0;
                  state_in = S_SCAN;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SCAN: begin
            addr_in = addr_next;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == LAST) state_in = S_DRAIN;
         end
         S_DRAIN: state_in = S_DONE;
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         addr_ff     <= '0;
         cnt_ff      <= '0;
         ev_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         addr_ff     <= addr_in;
         cnt_ff      <= cnt_in;
         ev_valid_ff <= (state_ff == S_SCAN);
      end
   end

   // hold the item's decision inputs for the length of the scan
   always_ff @(posedge clock) begin
      if (req_accept) begin
         is_sched_ff <= (req_action == ACT_SCHED);
         have_cur_ff <= req_have_current;
         cpu_ff      <= req_cpu_number;
      end
   end

   assign beat.valid  = ev_valid_ff;
   assign beat.last   = ev_last_ff;
   assign beat.kind   = rd_data_ff[KIND_W+STATUS_W-1:STATUS_W];
   assign beat.status = rd_data_ff[STATUS_W-1:0];

   rrtp_scan_acc #(
      .SLOTS (SLOTS),
      .CPUS  (CPUS)
   ) u_acc (
      .clock       (clock),
      .reset       (reset),
      .start       (req_accept && req_action == ACT_SCHED),
      .skip_guest  (skip_guest_ff),
      .run_guest   (run_guest_ff),
      .have_cur    (have_cur_ff),
      .cpu         (cpu_ff),
      .beat        (beat),
      .beat_addr   (ev_addr_ff),
      .dec_outcome (dec_outcome),
      .dec_slot    (dec_slot)
   );

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && out_free) begin
         rsp_outcome_ff <= is_sched_ff ? dec_outcome : OUT_WRITE;
         rsp_slot_ff    <= is_sched_ff ? dec_slot : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_outcome     = rsp_outcome_ff;
   assign rsp_chosen_slot = rsp_slot_ff;

endmodule

// ===== rtl/rrtp_scan_acc.sv =====
// Scan accumulator: folds slot table entries read during a scan into the
// facts a decision needs, and forms the decision. Depends on rrtp_pkg.
module rrtp_scan_acc import rrtp_pkg::*; #(
   parameter int SLOTS = SLOTS_DEF,
   parameter int CPUS  = CPUS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 skip_guest,
   input  logic                 run_guest,
   input  logic                 have_cur,
   input  logic [CPU_W-1:0]     cpu,
   input  scan_beat_type        beat,
   input  logic [$clog2(SLOTS)-1:0] beat_addr,
   output logic [OUT_W-1:0]     dec_outcome,
   output logic [SLOT_W-1:0]    dec_slot
);

   localparam int IW = $clog2(SLOTS);

   logic          rot_found_ff;
   logic [IW-1:0] rot_slot_ff;
   logic          keep_ff;
   logic [IW-1:0] keep_slot_ff;
   logic          any_ord_ff;
   logic          guest_found_ff;
   logic [IW-1:0] guest_slot_ff;
   logic          cpu_live_ff;

   logic live, eligible, is_guest, cpu_bad, cpu_match;

   assign live     = (beat.status == ST_RUNNABLE) || (beat.status == ST_RUNNING);
   assign is_guest = (beat.kind == KIND_GUEST);
   assign eligible = (beat.kind != KIND_IDLE) && !(skip_guest && is_guest);
   assign cpu_match = (32'(beat_addr) == 32'(cpu));
   assign cpu_bad   = (32'(cpu) >= 32'(CPUS)) || (32'(cpu) >= 32'(SLOTS));

   always_ff @(posedge clock) begin
      if (reset || start) begin
         rot_found_ff   <= 1'b0;
         keep_ff        <= 1'b0;
         any_ord_ff     <= 1'b0;
         guest_found_ff <= 1'b0;
         cpu_live_ff    <= 1'b0;
      end else if (beat.valid) begin
         // first runnable eligible slot in circular order, current slot excluded
         if (!beat.last && eligible && beat.status == ST_RUNNABLE && !rot_found_ff) begin
            rot_found_ff <= 1'b1;
         end
         if (beat.last && eligible && beat.status == ST_RUNNING) begin
            keep_ff <= 1'b1;
         end
         if (live && beat.kind != KIND_IDLE && !is_guest) begin
            any_ord_ff <= 1'b1;
         end
         if (live && is_guest && (!guest_found_ff || beat_addr < guest_slot_ff)) begin
            guest_found_ff <= 1'b1;
         end
         if (live && cpu_match) begin
            cpu_live_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (beat.valid) begin
         if (!beat.last && eligible && beat.status == ST_RUNNABLE && !rot_found_ff) begin
            rot_slot_ff <= beat_addr;
         end
         // hold the current slot's index; the read address moves on after the scan
         if (beat.last) begin
            keep_slot_ff <= beat_addr;
         end
         if (live && is_guest && (!guest_found_ff || beat_addr < guest_slot_ff)) begin
            guest_slot_ff <= beat_addr;
         end
      end
   end

   always_comb begin
      dec_outcome = OUT_RUN;
      dec_slot    = '0;
      if (have_cur && rot_found_ff) begin
         dec_slot = SLOT_W'(rot_slot_ff);
      end else if (have_cur && keep_ff) begin
         dec_slot = SLOT_W'(keep_slot_ff);
      end else if (!any_ord_ff) begin
         if (run_guest && guest_found_ff) begin
            dec_slot = SLOT_W'(guest_slot_ff);
         end else begin
            dec_outcome = OUT_NONE;
         end
      end else if (cpu_bad || !cpu_live_ff) begin
         dec_outcome = OUT_NOIDLE;
      end else begin
         dec_slot = SLOT_W'(cpu);
      end
   end

endmodule

// ===== sim/round_robin_task_picker_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for round_robin_task_picker: slot writes and schedule
// requests with random idling, every result beat checked against a slot-table
// predictor or a written expectation. Depends on rrtp_pkg and the block's RTL.
module round_robin_task_picker_tb import rrtp_pkg::*;;

   localparam int N_SLOTS      = SLOTS_DEF;
   localparam int N_CPUS       = CPUS_DEF;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = N_SLOTS + 16;
   localparam int PHASE_ITEMS  = 150;

   localparam logic [KIND_W-1:0]   KIND_ORDINARY = 2'd0;
   localparam logic [KIND_W-1:0]   KIND_SPARE    = 2'd3;
   localparam logic [STATUS_W-1:0] ST_BLOCKED    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_SPARE      = 2'd3;

   typedef struct packed {
      logic                action;
      logic [SLOT_W-1:0]   slot_index;
      logic [KIND_W-1:0]   slot_kind;
      logic [STATUS_W-1:0] slot_status;
      logic                have_current;
      logic [SLOT_W-1:0]   current_slot;
      logic [CPU_W-1:0]    cpu_number;
   } pick_item_type;

   typedef struct packed {
      logic [OUT_W-1:0]  outcome;
      logic [SLOT_W-1:0] slot;
   } pick_result_type;

   typedef struct {
      bit              is_cfg;
      bit              skip;
      bit              run_guest;
      pick_item_type   it;
      bit              typed;
      pick_result_type want;
   } plan_row_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_action;
   logic [SLOT_W-1:0]   req_slot_index;
   logic [KIND_W-1:0]   req_slot_kind;
   logic [STATUS_W-1:0] req_slot_status;
   logic                req_have_current;
   logic [SLOT_W-1:0]   req_current_slot;
   logic [CPU_W-1:0]    req_cpu_number;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [OUT_W-1:0]    rsp_outcome;
   logic [SLOT_W-1:0]   rsp_chosen_slot;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [CSR_AW-1:0]   paddr;
   logic [CSR_DW-1:0]   pwdata;
   logic [CSR_DW-1:0]   prdata;
   logic                pready;

   // predictor state: mirror of the slot table and the two control bits
   logic [KIND_W-1:0]   kind_tbl [N_SLOTS];
   logic [STATUS_W-1:0] status_tbl [N_SLOTS];
   bit                  skip_guest_cfg;
   bit                  run_guest_cfg;

   pick_result_type due_results[$];
   pick_result_type due_beat;
   int              errors = 0;
   int              items_sent = 0;
   int              cycle_count = 0;
   int              stall_left = 0;
   bit              idling_on = 1'b1;

   round_robin_task_picker uut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic bit slot_is_live(input int s);
      return status_tbl[s] == ST_RUNNABLE || status_tbl[s] == ST_RUNNING;
   endfunction

   function automatic bit slot_in_rotation(input int s);
      if (kind_tbl[s] == KIND_IDLE)
         return 1'b0;
      return !(skip_guest_cfg && kind_tbl[s] == KIND_GUEST);
   endfunction

   // apply one item to the mirrored table and return the decision it yields
   function automatic pick_result_type predict_pick(input pick_item_type it);
      pick_result_type r;
      int              cur;
      int              s;
      bit              ordinary_live;
      r.outcome = OUT_RUN;
      r.slot    = '0;
      if (it.action == ACT_WRITE) begin
         if (it.slot_index < N_SLOTS) begin
            kind_tbl[it.slot_index]   = it.slot_kind;
            status_tbl[it.slot_index] = it.slot_status;
         end
         r.outcome = OUT_WRITE;
         return r;
      end
      if (it.have_current) begin
         cur = int'(it.current_slot) % N_SLOTS;
         for (int k = 1; k < N_SLOTS; k++) begin
            s = (cur + k) % N_SLOTS;
            if (slot_in_rotation(s) && status_tbl[s] == ST_RUNNABLE) begin
               r.slot = SLOT_W'(s);
               return r;
            end
         end
         if (slot_in_rotation(cur) && status_tbl[cur] == ST_RUNNING) begin
            r.slot = SLOT_W'(cur);
            return r;
         end
      end
      ordinary_live = 1'b0;
      for (int k = 0; k < N_SLOTS; k++)
         if (kind_tbl[k] != KIND_IDLE && kind_tbl[k] != KIND_GUEST && slot_is_live(k))
            ordinary_live = 1'b1;
      if (!ordinary_live) begin
         if (run_guest_cfg) begin
            for (int k = 0; k < N_SLOTS; k++)
               if (kind_tbl[k] == KIND_GUEST && slot_is_live(k)) begin
                  r.slot = SLOT_W'(k);
                  return r;
               end
         end
         r.outcome = OUT_NONE;
         return r;
      end
      if (it.cpu_number >= N_CPUS || it.cpu_number >= N_SLOTS ||
          !slot_is_live(it.cpu_number)) begin
         r.outcome = OUT_NOIDLE;
         return r;
      end
      r.slot = SLOT_W'(it.cpu_number);
      return r;
   endfunction

   function automatic pick_item_type random_item();
      pick_item_type it;
      it.action       = 1'($urandom_range(0, 1));
      it.slot_index   = SLOT_W'($urandom_range(0, N_SLOTS - 1));
      it.slot_kind    = KIND_W'($urandom_range(0, 3));
      it.slot_status  = STATUS_W'($urandom_range(0, 3));
      it.have_current = 1'($urandom_range(0, 1));
      it.current_slot = SLOT_W'($urandom_range(0, N_SLOTS - 1));
      it.cpu_number   = CPU_W'($urandom_range(0, 7));
      return it;
   endfunction

   function automatic plan_row_type cf(input bit skip, input bit run_guest);
      plan_row_type row;
      row           = '{default: '0};
      row.is_cfg    = 1'b1;
      row.skip      = skip;
      row.run_guest = run_guest;
      return row;
   endfunction

   function automatic plan_row_type wr(input logic [SLOT_W-1:0] idx,
                                       input logic [KIND_W-1:0] kind,
                                       input logic [STATUS_W-1:0] status);
      plan_row_type row;
      row                = '{default: '0};
      row.it.action      = ACT_WRITE;
      row.it.slot_index  = idx;
      row.it.slot_kind   = kind;
      row.it.slot_status = status;
      row.typed          = 1'b1;
      row.want.outcome   = OUT_WRITE;
      return row;
   endfunction

   function automatic plan_row_type pk(input bit have, input logic [SLOT_W-1:0] cur,
                                       input logic [CPU_W-1:0] cpu);
      plan_row_type row;
      row                 = '{default: '0};
      row.it.action       = ACT_SCHED;
      row.it.have_current = have;
      row.it.current_slot = cur;
      row.it.cpu_number   = cpu;
      return row;
   endfunction

   function automatic plan_row_type pkt(input bit have, input logic [SLOT_W-1:0] cur,
                                        input logic [CPU_W-1:0] cpu,
                                        input logic [OUT_W-1:0] outcome,
                                        input logic [SLOT_W-1:0] slot);
      plan_row_type row;
      row              = pk(have, cur, cpu);
      row.typed        = 1'b1;
      row.want.outcome = outcome;
      row.want.slot    = slot;
      return row;
   endfunction

   // one beat on the request channel; expectation is logged at acceptance
   task automatic send_item(input pick_item_type it, input bit typed,
                            input pick_result_type typed_want);
      pick_result_type got;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= it.action;
      req_slot_index   <= it.slot_index;
      req_slot_kind    <= it.slot_kind;
      req_slot_status  <= it.slot_status;
      req_have_current <= it.have_current;
      req_current_slot <= it.current_slot;
      req_cpu_number   <= it.cpu_number;
      do @(posedge clock); while (!req_ready);
      got = predict_pick(it);
      due_results.push_back(typed ? typed_want : got);
      items_sent++;
   endtask

   task automatic wait_for_results();
      while (due_results.size() != 0) @(posedge clock);
   endtask

   // write one register, then read it back
   task automatic write_csr(input logic reg_sel, input bit value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= CSR_DW'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (reg_sel)
         REG_SKIP_GUEST: skip_guest_cfg = value;
         REG_RUN_GUEST:  run_guest_cfg  = value;
         default: ;
      endcase
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== CSR_DW'(value)) begin
         $display("%0t: register %0d read back: expected %0h, got %0h",
                  $time, reg_sel, value, prdata);
         errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // a burst of table writes followed by a few decisions
   task automatic run_scene();
      pick_item_type it;
      int            live_slots[$];
      // drop every live slot now and then so empty-table paths get reached
      if ($urandom_range(0, 2) == 0) begin
         for (int s = 0; s < N_SLOTS; s++)
            if (slot_is_live(s)) begin
               it             = random_item();
               it.action      = ACT_WRITE;
               it.slot_index  = SLOT_W'(s);
               it.slot_status = ($urandom_range(0, 3) == 0) ? ST_SPARE : ST_BLOCKED;
               send_item(it, 1'b0, '0);
            end
      end
      repeat ($urandom_range(1, 6)) begin
         it        = random_item();
         it.action = ACT_WRITE;
         if ($urandom_range(0, 1))
            it.slot_index = SLOT_W'($urandom_range(0, N_CPUS - 1));
         case ($urandom_range(0, 9))
            0, 1, 2, 3: it.slot_kind = KIND_ORDINARY;
            4, 5:       it.slot_kind = KIND_IDLE;
            6, 7, 8:    it.slot_kind = KIND_GUEST;
            default:    it.slot_kind = KIND_SPARE;
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2, 3: it.slot_status = ST_BLOCKED;
            4, 5:       it.slot_status = ST_RUNNABLE;
            6, 7, 8:    it.slot_status = ST_RUNNING;
            default:    it.slot_status = ST_SPARE;
         endcase
         send_item(it, 1'b0, '0);
      end
      repeat ($urandom_range(1, 3)) begin
         it              = random_item();
         it.action       = ACT_SCHED;
         it.have_current = ($urandom_range(0, 3) != 0);
         live_slots      = {};
         for (int s = 0; s < N_SLOTS; s++)
            if (slot_is_live(s))
               live_slots.push_back(s);
         if (live_slots.size() != 0 && $urandom_range(0, 1))
            it.current_slot =
               SLOT_W'(live_slots[$urandom_range(0, live_slots.size() - 1)]);
         send_item(it, 1'b0, '0);
      end
      if ($urandom_range(0, 9) == 0)
         send_item(random_item(), 1'b0, '0);
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left = $urandom_range(0, 16);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_results.size() == 0) begin
            $display("%0t: result beat with nothing due: outcome %0d, slot %0d",
                     $time, rsp_outcome, rsp_chosen_slot);
            errors++;
         end else begin
            due_beat = due_results.pop_front();
            if (rsp_outcome !== due_beat.outcome) begin
               $display("%0t: outcome expected %0d, got %0d",
                        $time, due_beat.outcome, rsp_outcome);
               errors++;
            end
            if (rsp_chosen_slot !== due_beat.slot) begin
               $display("%0t: chosen_slot expected %0d, got %0d",
                        $time, due_beat.slot, rsp_chosen_slot);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("round_robin_task_picker test failed");
         $finish;
      end
   end

   initial begin
      plan_row_type plan[$];
      int           phase_end;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_action       = ACT_WRITE;
      req_slot_index   = '0;
      req_slot_kind    = KIND_ORDINARY;
      req_slot_status  = ST_BLOCKED;
      req_have_current = 1'b0;
      req_current_slot = '0;
      req_cpu_number   = '0;
      rsp_ready        = 1'b0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      for (int s = 0; s < N_SLOTS; s++) begin
         kind_tbl[s]   = KIND_ORDINARY;
         status_tbl[s] = ST_BLOCKED;
      end
      skip_guest_cfg = 1'b0;
      run_guest_cfg  = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      plan = '{
         cf(1'b0, 1'b0),
         pkt(1'b0, 0, 0, OUT_NONE, 0),
         pkt(1'b1, 63, 7, OUT_NONE, 0),
         wr(63, KIND_ORDINARY, ST_RUNNABLE),
         pkt(1'b1, 63, 0, OUT_NOIDLE, 0),
         pkt(1'b1, 0, 0, OUT_RUN, 63),
         wr(0, KIND_IDLE, ST_RUNNING),
         pk(1'b0, 0, 0),
         wr(63, KIND_SPARE, ST_RUNNING),   // odd kind code acts as ordinary
         pk(1'b1, 63, 0),
         pkt(1'b1, 5, 7, OUT_NOIDLE, 0),
         wr(63, KIND_ORDINARY, ST_SPARE),  // odd status code is not live
         pkt(1'b1, 63, 0, OUT_NONE, 0),
         wr(42, KIND_GUEST, ST_RUNNABLE),
         pk(1'b1, 0, 0),
         cf(1'b1, 1'b1),
         pk(1'b1, 0, 0),
         wr(42, KIND_GUEST, ST_BLOCKED),
         pkt(1'b1, 0, 0, OUT_NONE, 0),
         wr(7, KIND_GUEST, ST_RUNNING),
         wr(10, KIND_ORDINARY, ST_RUNNING),
         pk(1'b0, 10, 7),                  // idle slot of guest kind still runs
         wr(20, KIND_GUEST, ST_RUNNING),
         pkt(1'b1, 20, 3, OUT_NOIDLE, 0),
         pk(1'b1, 10, 5)
      };
      foreach (plan[i]) begin
         if (plan[i].is_cfg) begin
            req_valid <= 1'b0;
            wait_for_results();
            write_csr(REG_SKIP_GUEST, plan[i].skip);
            write_csr(REG_RUN_GUEST, plan[i].run_guest);
         end else begin
            send_item(plan[i].it, plan[i].typed, plan[i].want);
         end
      end

      // four settings, both extremes of each bit; the last phase runs flat out
      for (int p = 0; p < 4; p++) begin
         req_valid <= 1'b0;
         wait_for_results();
         idling_on = (p != 3);
         write_csr(REG_SKIP_GUEST, !p[0]);
         write_csr(REG_RUN_GUEST, p < 2);
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end)
            run_scene();
      end

      req_valid <= 1'b0;
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("round_robin_task_picker test passed");
      else
         $display("round_robin_task_picker test failed");
      $finish;
   end

endmodule

// ===== round_robin_task_picker.f =====
rtl/rrtp_pkg.sv
rtl/rrtp_scan_acc.sv
rtl/round_robin_task_picker.sv
sim/round_robin_task_picker_tb.sv
